[rtl/bms_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the bounded merge sorter.
package bms_pkg;

    localparam int unsigned DATA_W = 32;

    typedef logic [DATA_W-1:0] data_t;

    // Top-level run sequencing
    typedef enum logic [1:0] {
        S_LOAD,
        S_START,
        S_MERGE,
        S_DRAIN
    } core_state_t;

    // Merge engine sequencing
    typedef enum logic [1:0] {
        M_IDLE,
        M_SETUP,
        M_MERGE
    } merge_state_t;

    // Status from the merge engine to the run controller
    typedef struct packed {
        logic busy;
        logic done;
        logic result_in_b;
    } merge_status_t;

endpackage

[rtl/bms_bank.sv]
`timescale 1ns / 1ps
// One value bank: single write port, two registered read ports with enables.
module bms_bank #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  bms_pkg::data_t      wdata,
    input  logic                re0,
    input  logic [ADDR_W-1:0]   raddr0,
    output bms_pkg::data_t      rdata0,
    input  logic                re1,
    input  logic [ADDR_W-1:0]   raddr1,
    output bms_pkg::data_t      rdata1
);
    import bms_pkg::*;

    data_t mem [DEPTH];
    data_t rd0_reg;
    data_t rd1_reg;

    // Write, and registered reads; read data holds while disabled
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re0)
        begin
            rd0_reg <= mem[raddr0];
        end
        if (re1)
        begin
            rd1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;

endmodule

[rtl/bms_merge.sv]
`timescale 1ns / 1ps
// Bottom-up merge engine: ping-pongs passes between the two banks.
module bms_merge #(
    parameter int unsigned MAX_ITEMS = 64,
    parameter int unsigned CNT_W     = $clog2(MAX_ITEMS + 1),
    parameter int unsigned ADDR_W    = $clog2(MAX_ITEMS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [CNT_W-1:0]        n,
    input  bms_pkg::data_t          rdata0,
    input  bms_pkg::data_t          rdata1,
    output bms_pkg::merge_status_t  status,
    output logic                    rd_en,
    output logic [ADDR_W-1:0]       raddr0,
    output logic [ADDR_W-1:0]       raddr1,
    output logic                    we,
    output logic [ADDR_W-1:0]       waddr,
    output bms_pkg::data_t          wdata
);
    import bms_pkg::*;

    // Room for lo + 2 * width without wrapping
    localparam int unsigned SUM_W = CNT_W + 2;

    merge_state_t      state_reg, state_next;
    logic [SUM_W-1:0]  width_reg, width_next;
    logic [SUM_W-1:0]  lo_reg, lo_next;
    logic [SUM_W-1:0]  i_reg, i_next;
    logic [SUM_W-1:0]  j_reg, j_next;
    logic [SUM_W-1:0]  mid_reg, mid_next;
    logic [SUM_W-1:0]  hi_reg, hi_next;
    logic [SUM_W-1:0]  k_reg, k_next;
    logic [SUM_W-1:0]  n_reg, n_next;
    logic              src_b_reg, src_b_next;
    logic              done_reg, done_next;

    logic [SUM_W-1:0]  mid_raw, hi_raw, seg_mid, seg_hi, width_dbl;
    logic              take_left;

    // Clip the current segment bounds to the run length
    assign width_dbl = width_reg << 1;
    assign mid_raw   = lo_reg + width_reg;
    assign hi_raw    = lo_reg + width_dbl;
    assign seg_mid   = (mid_raw > n_reg) ? n_reg : mid_raw;
    assign seg_hi    = (hi_raw > n_reg) ? n_reg : hi_raw;

    // Left run wins ties so equal values keep arrival order
    assign take_left = (i_reg < mid_reg) &&
                       ((j_reg >= hi_reg) || ($signed(rdata0) <= $signed(rdata1)));

    // Next state and memory requests
    always_comb
    begin
        state_next = state_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        src_b_next = src_b_reg;
        done_next  = 1'b0;
        rd_en      = 1'b0;
        raddr0     = i_reg[ADDR_W-1:0];
        raddr1     = j_reg[ADDR_W-1:0];
        we         = 1'b0;
        waddr      = k_reg[ADDR_W-1:0];
        wdata      = take_left ? rdata0 : rdata1;

        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    n_next     = SUM_W'(n);
                    width_next = SUM_W'(1);
                    lo_next    = '0;
                    src_b_next = 1'b0;
                    if (n <= CNT_W'(1))
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = M_SETUP;
                    end
                end
            end

            M_SETUP:
            begin
                // Fetch the heads of both runs of the segment
                i_next     = lo_reg;
                j_next     = seg_mid;
                mid_next   = seg_mid;
                hi_next    = seg_hi;
                k_next     = lo_reg;
                rd_en      = 1'b1;
                raddr0     = lo_reg[ADDR_W-1:0];
                raddr1     = seg_mid[ADDR_W-1:0];
                state_next = M_MERGE;
            end

            M_MERGE:
            begin
                // Emit one value and advance the run it came from
                we = 1'b1;
                if (take_left)
                begin
                    i_next = SUM_W'(i_reg + 1'b1);
                end
                else
                begin
                    j_next = SUM_W'(j_reg + 1'b1);
                end
                rd_en  = 1'b1;
                raddr0 = i_next[ADDR_W-1:0];
                raddr1 = j_next[ADDR_W-1:0];
                k_next = SUM_W'(k_reg + 1'b1);
                if (k_next == hi_reg)
                begin
                    lo_next    = hi_reg;
                    state_next = M_SETUP;
                    if (hi_reg >= n_reg)
                    begin
                        // Pass done: swap banks, double the run width
                        src_b_next = !src_b_reg;
                        width_next = width_dbl;
                        lo_next    = '0;
                        if (width_dbl >= n_reg)
                        begin
                            state_next = M_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    // Hold state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            src_b_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            src_b_reg <= src_b_next;
            done_reg  <= done_next;
        end
    end

    // Advance pointers
    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
        lo_reg    <= lo_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        k_reg     <= k_next;
        n_reg     <= n_next;
    end

    assign status.busy        = (state_reg != M_IDLE);
    assign status.done        = done_reg;
    assign status.result_in_b = src_b_reg;

`ifndef SYNTHESIS
    a_merge_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == M_MERGE) |-> (k_reg < hi_reg) && (i_reg <= mid_reg) && (j_reg <= hi_reg))
        else $error("merge pointers out of segment bounds");

    a_merge_output_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == M_MERGE) |-> (k_reg + mid_reg == i_reg + j_reg))
        else $error("merge output index does not match consumed inputs");

    a_merge_run_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != M_IDLE) |-> (n_reg > SUM_W'(1)))
        else $error("merge running on a run shorter than two values");
`endif

endmodule

[rtl/bounded_merge_sorter_core.sv]
`timescale 1ns / 1ps
// Top level of the bounded merge sorter: loading, run control and result drain.
//
// Usage:
//   Input channel (item_valid / item_stall) carries item_value and item_is_last.
//   Up to MAX_ITEMS values per run are stored; later values are dropped and the
//   run's results carry overflowed = 1.
//   After the transaction with item_is_last, the block sorts the run ascending
//   (stable) and returns every stored value on the result channel
//   (result_valid / result_stall), result_is_last on the final one.
// Sequence, for a run of n stored values:
//   load (one per item), a start step and a hand-over step, then
//   ceil(log2 n) merge passes, each writing all n values plus a setup step
//   per merged segment, then one result per cycle from the result bank
//   while the receiver does not stall.
// item_stall is high from the last item of a run until the final result has
//   entered the output register; a stalled receiver holds the drain.
// Reset clears the run (empty, no overflow) and empties the result channel;
//   the value banks need no clearing.
module bounded_merge_sorter_core #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic signed [bms_pkg::DATA_W-1:0]    item_value,
    input  logic                                 item_is_last,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [bms_pkg::DATA_W-1:0]    sorted_value,
    output logic                                 result_is_last,
    output logic                                 overflowed
);
    import bms_pkg::*;

    localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int unsigned ADDR_W = $clog2(MAX_ITEMS);

    core_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  run_n_reg;
    logic              run_ovf_reg;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic              pend_reg;
    logic              pend_last_reg;
    logic              out_valid_reg;
    data_t             out_value_reg;
    logic              out_last_reg;
    logic              out_ovf_reg;

    logic              item_accept;
    logic              has_room;
    logic              load_we;
    logic              out_accept;
    logic              remaining;
    logic              load_out;
    logic              issue;
    logic              drain_active;
    logic              merge_start;

    merge_status_t     m_stat;
    logic              m_rd_en;
    logic [ADDR_W-1:0] m_raddr0, m_raddr1, m_waddr;
    logic              m_we;
    data_t             m_wdata;
    data_t             src_rdata0, src_rdata1;

    logic              we_a, we_b, re0_a, re0_b, re1_a, re1_b;
    logic [ADDR_W-1:0] waddr_a, raddr0_x;
    data_t             wdata_a;
    data_t             a_rdata0, a_rdata1, b_rdata0, b_rdata1;
    logic              src_b;

    // Input side: take items only while loading
    assign item_stall  = (state_reg != S_LOAD);
    assign item_accept = item_valid && !item_stall;
    assign has_room    = (count_reg < CNT_W'(MAX_ITEMS));
    assign load_we     = item_accept && has_room;

    // Drain side: one read in flight, held in the bank's read register
    assign drain_active = (state_reg == S_DRAIN);
    assign out_accept   = out_valid_reg && !result_stall;
    assign remaining    = drain_active && (rd_idx_reg < run_n_reg);
    assign load_out     = pend_reg && (!out_valid_reg || !result_stall);
    assign issue        = remaining && (!pend_reg || load_out);

    // Run sequencing
    always_comb
    begin
        state_next  = state_reg;
        merge_start = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (item_accept && item_is_last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                merge_start = 1'b1;
                state_next  = S_MERGE;
            end
            S_MERGE:
            begin
                if (m_stat.done)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (load_out && pend_last_reg)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Hold control state; count the run and latch its length at the last item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            run_n_reg     <= '0;
            run_ovf_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (item_accept)
            begin
                if (item_is_last)
                begin
                    run_n_reg   <= has_room ? CNT_W'(count_reg + 1'b1) : count_reg;
                    run_ovf_reg <= ovf_reg || !has_room;
                    count_reg   <= '0;
                    ovf_reg     <= 1'b0;
                end
                else if (has_room)
                begin
                    count_reg <= CNT_W'(count_reg + 1'b1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end

            if (state_reg == S_START)
            begin
                rd_idx_reg <= '0;
            end
            else if (issue)
            begin
                rd_idx_reg <= CNT_W'(rd_idx_reg + 1'b1);
            end

            if (issue)
            begin
                pend_reg      <= 1'b1;
                pend_last_reg <= (CNT_W'(rd_idx_reg + 1'b1) == run_n_reg);
            end
            else if (load_out)
            begin
                pend_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_value_reg <= src_rdata0;
            out_last_reg  <= pend_last_reg;
            out_ovf_reg   <= run_ovf_reg;
        end
    end

    assign result_valid   = out_valid_reg;
    assign sorted_value   = signed'(out_value_reg);
    assign result_is_last = out_last_reg;
    assign overflowed     = out_ovf_reg;

    // Bank steering: the merge reads the source bank and writes the other; loads always write bank A
    assign src_b    = m_stat.result_in_b;
    assign we_a     = load_we || (m_we && src_b);
    assign waddr_a  = load_we ? count_reg[ADDR_W-1:0] : m_waddr;
    assign wdata_a  = load_we ? data_t'(item_value) : m_wdata;
    assign we_b     = m_we && !src_b;
    assign raddr0_x = drain_active ? rd_idx_reg[ADDR_W-1:0] : m_raddr0;
    assign re0_a    = (m_rd_en || issue) && !src_b;
    assign re0_b    = (m_rd_en || issue) && src_b;
    assign re1_a    = m_rd_en && !src_b;
    assign re1_b    = m_rd_en && src_b;

    assign src_rdata0 = src_b ? b_rdata0 : a_rdata0;
    assign src_rdata1 = src_b ? b_rdata1 : a_rdata1;

    bms_bank #(
        .DEPTH  (MAX_ITEMS),
        .ADDR_W (ADDR_W)
    ) u_bank_a (
        .clk    (clk),
        .we     (we_a),
        .waddr  (waddr_a),
        .wdata  (wdata_a),
        .re0    (re0_a),
        .raddr0 (raddr0_x),
        .rdata0 (a_rdata0),
        .re1    (re1_a),
        .raddr1 (m_raddr1),
        .rdata1 (a_rdata1)
    );

    bms_bank #(
        .DEPTH  (MAX_ITEMS),
        .ADDR_W (ADDR_W)
    ) u_bank_b (
        .clk    (clk),
        .we     (we_b),
        .waddr  (m_waddr),
        .wdata  (m_wdata),
        .re0    (re0_b),
        .raddr0 (raddr0_x),
        .rdata0 (b_rdata0),
        .re1    (re1_b),
        .raddr1 (m_raddr1),
        .rdata1 (b_rdata1)
    );

    bms_merge #(
        .MAX_ITEMS (MAX_ITEMS),
        .CNT_W     (CNT_W),
        .ADDR_W    (ADDR_W)
    ) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (merge_start),
        .n      (run_n_reg),
        .rdata0 (src_rdata0),
        .rdata1 (src_rdata1),
        .status (m_stat),
        .rd_en  (m_rd_en),
        .raddr0 (m_raddr0),
        .raddr1 (m_raddr1),
        .we     (m_we),
        .waddr  (m_waddr),
        .wdata  (m_wdata)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("stored count exceeds capacity");

    a_done_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
        m_stat.done |-> (state_reg == S_MERGE))
        else $error("merge finished outside the merge phase");

    a_drain_idle_merge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> !m_stat.busy)
        else $error("drain overlaps a running merge");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && pend_last_reg) |=> (state_reg == S_LOAD) && !pend_reg && result_is_last)
        else $error("final result did not close the run");
`endif

endmodule
